@@ src/fcd_pkg.sv @@
// shared types and constants of the circular-delay fir filter
`timescale 1ns / 1ps

package fcd_pkg;

   // build defaults
   localparam int MAX_TAPS_DEF    = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   // field widths
   localparam int TAP_COUNT_W  = 7;
   localparam int INDEX_W      = 6;
   localparam int VALUE_W      = 16;
   localparam int COEF_W       = 16;
   localparam int COEF_FRAC    = 15;
   localparam int OUT_W        = 16;
   localparam int REQ_TDATA_W  = 24;
   localparam int RSP_TDATA_W  = 16;

   // tap count after reset
   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 7'd64;

   // what a request beat carries
   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_COEF   = 1'b1
   } command_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;        // store sample, step write position, clear sum
      logic coef_write;   // store one coefficient
      logic issue;        // read one tap pair
      logic load_out;     // move saturated sum to the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_tap;     // current read is the final tap
      logic pipe_busy;    // read or product stage still holds a tap
      logic out_free;     // output register can take a result this cycle
   } status_type;

endpackage

@@ src/fcd_ctrl.sv @@
// controller of the circular-delay fir filter: request handshake and tap sequencing
`timescale 1ns / 1ps

module fcd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  fcd_pkg::command_type req_command,
   input  fcd_pkg::status_type  status,
   output fcd_pkg::cmd_type     cmd
);
   import fcd_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_command == CMD_COEF) begin
                  cmd.coef_write = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            cmd.issue = 1'b1;
            if (status.last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy && status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   // last tap is still in flight right after the read phase ends
   a_drain_holds_tap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && $past(state_ff) == ST_MAC) |-> status.pipe_busy)
      else $error("drain entered with empty pipeline");

   // a result is never loaded over one that is still waiting
   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("output register overwritten");

   // an accepted sample always starts a read phase
   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_command == CMD_SAMPLE) |=> state_ff == ST_MAC)
      else $error("sample beat did not start taps");
`endif

endmodule

@@ src/fcd_datapath.sv @@
// datapath of the circular-delay fir filter: stores, shared multiply-accumulate, output register
`timescale 1ns / 1ps

module fcd_datapath #(
   parameter int MAX_TAPS    = fcd_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = fcd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [fcd_pkg::TAP_COUNT_W-1:0] csr_wr_data,
   input  logic [fcd_pkg::INDEX_W-1:0]     req_coeff_index,
   input  logic [fcd_pkg::VALUE_W-1:0]     req_value,
   input  fcd_pkg::cmd_type                cmd,
   output fcd_pkg::status_type             status,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [fcd_pkg::OUT_W-1:0]       rsp_filtered_sample,
   output logic                            rsp_clipped
);
   import fcd_pkg::*;

   localparam int ADDR_W = $clog2(MAX_TAPS);
   localparam int CNT_W  = $clog2(MAX_TAPS + 1);
   localparam int PROD_W = SAMPLE_BITS + COEF_W;
   localparam int ACC_W  = PROD_W + ADDR_W;
   localparam int YW     = ACC_W - COEF_FRAC;
   localparam int YX     = YW + OUT_W;
   localparam int IXW    = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
   localparam logic signed [YW-1:0] Y_HI = YW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [YW-1:0] Y_LO = ~Y_HI;

   logic [TAP_COUNT_W-1:0]   tap_count_ff;
   logic [CNT_W-1:0]         tap_n;
   logic [ADDR_W-1:0]        wp_ff;
   logic [ADDR_W:0]          wp_plus;
   logic [ADDR_W-1:0]        wp_next;
   logic [ADDR_W-1:0]        k_ff;
   logic [ADDR_W-1:0]        idx_ff;
   logic [ADDR_W:0]          idx_plus;
   logic [ADDR_W-1:0]        idx_next;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic [IXW-1:0]           ci_wide;
   logic [ADDR_W-1:0]        ci_addr;
   logic                     ci_ok;

   logic signed [SAMPLE_BITS-1:0] dl_mem [MAX_TAPS];
   logic signed [COEF_W-1:0]      cf_mem [MAX_TAPS];
   logic [MAX_TAPS-1:0]      dl_vld_ff;
   logic [MAX_TAPS-1:0]      cf_vld_ff;

   logic signed [SAMPLE_BITS-1:0] dl_rd_ff;
   logic signed [COEF_W-1:0]      cf_rd_ff;
   logic                     dl_rd_ok_ff;
   logic                     cf_rd_ok_ff;
   logic                     rd_vld_ff;
   logic signed [SAMPLE_BITS-1:0] dl_op;
   logic signed [COEF_W-1:0]      cf_op;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   logic signed [YW-1:0]     y_short;
   logic signed [YW-1:0]     y_sat;
   logic signed [YX-1:0]     y_ext;
   logic                     y_clip;
   logic                     rsp_vld_ff;
   logic [OUT_W-1:0]         rsp_data_ff;
   logic                     rsp_clip_ff;

   // tap count register
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RESET;
      end else if (csr_wr_en) begin
         tap_count_ff <= csr_wr_data;
      end
   end

   // taps in use: zero reads as one, beyond the store depth reads as the depth
   always_comb begin
      if (tap_count_ff == '0) begin
         tap_n = CNT_W'(1);
      end else if (32'(tap_count_ff) > 32'(MAX_TAPS)) begin
         tap_n = CNT_W'(MAX_TAPS);
      end else begin
         tap_n = CNT_W'(tap_count_ff);
      end
   end

   // sample taken from the low bits of the value field
   if (SAMPLE_BITS <= VALUE_W) begin : g_sample_narrow
      assign sample_in = req_value[SAMPLE_BITS-1:0];
   end else begin : g_sample_wide
      assign sample_in = SAMPLE_BITS'(req_value);
   end

   // coefficient address, writes past the store depth are dropped
   assign ci_wide = IXW'(req_coeff_index);
   assign ci_addr = ci_wide[ADDR_W-1:0];
   assign ci_ok   = 32'(req_coeff_index) < 32'(MAX_TAPS);

   // position steps, wrapping at the tap count
   assign wp_plus  = {1'b0, wp_ff} + (ADDR_W+1)'(1);
   assign wp_next  = (32'(wp_plus) >= 32'(tap_n)) ? '0 : wp_plus[ADDR_W-1:0];
   assign idx_plus = {1'b0, idx_ff} + (ADDR_W+1)'(1);
   assign idx_next = (32'(idx_plus) >= 32'(tap_n)) ? '0 : idx_plus[ADDR_W-1:0];

   // write position and tap counters
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         k_ff   <= '0;
         idx_ff <= '0;
      end else if (cmd.start) begin
         wp_ff  <= wp_next;
         k_ff   <= '0;
         idx_ff <= wp_next;
      end else if (cmd.issue) begin
         k_ff   <= k_ff + ADDR_W'(1);
         idx_ff <= idx_next;
      end
   end

   assign status.last_tap = (32'(k_ff) + 32'd1) == 32'(tap_n);

   // delay line store
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         dl_mem[wp_ff] <= sample_in;
      end
      if (cmd.issue) begin
         dl_rd_ff <= dl_mem[idx_ff];
      end
   end

   // coefficient store
   always_ff @(posedge clock) begin
      if (cmd.coef_write && ci_ok) begin
         cf_mem[ci_addr] <= req_value;
      end
      if (cmd.issue) begin
         cf_rd_ff <= cf_mem[k_ff];
      end
   end

   // written marks, an unwritten entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         dl_vld_ff   <= '0;
         cf_vld_ff   <= '0;
         dl_rd_ok_ff <= 1'b0;
         cf_rd_ok_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            dl_vld_ff[wp_ff] <= 1'b1;
         end
         if (cmd.coef_write && ci_ok) begin
            cf_vld_ff[ci_addr] <= 1'b1;
         end
         if (cmd.issue) begin
            dl_rd_ok_ff <= dl_vld_ff[idx_ff];
            cf_rd_ok_ff <= cf_vld_ff[k_ff];
         end
      end
   end

   // pipeline occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   assign status.pipe_busy = rd_vld_ff || prod_vld_ff;

   // product stage
   assign dl_op = dl_rd_ok_ff ? dl_rd_ff : '0;
   assign cf_op = cf_rd_ok_ff ? cf_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         prod_ff <= PROD_W'(dl_op) * PROD_W'(cf_op);
      end
   end

   // accumulate stage
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // scale by the coefficient fraction (floor) and saturate
   always_comb begin
      y_short = acc_ff[ACC_W-1:COEF_FRAC];
      y_clip  = 1'b0;
      y_sat   = y_short;
      if (y_short > Y_HI) begin
         y_sat  = Y_HI;
         y_clip = 1'b1;
      end else if (y_short < Y_LO) begin
         y_sat  = Y_LO;
         y_clip = 1'b1;
      end
      y_ext = YX'(y_sat);
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= y_ext[OUT_W-1:0];
         rsp_clip_ff <= y_clip;
      end
   end

   assign status.out_free     = !rsp_vld_ff || rsp_tready;
   assign rsp_tvalid          = rsp_vld_ff;
   assign rsp_filtered_sample = rsp_data_ff;
   assign rsp_clipped         = rsp_clip_ff;

`ifndef NO_ASSERTIONS
   // the sum is complete when it is moved out
   a_load_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !rd_vld_ff && !prod_vld_ff)
      else $error("result loaded with taps in flight");

   // the write position stays inside the active line
   a_wp_in_line: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.start) |-> 32'(wp_ff) < 32'(tap_n))
      else $error("write position past tap count");

   // reads never run past the taps in use
   a_tap_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (32'(k_ff) < 32'(tap_n) && 32'(idx_ff) < 32'(tap_n)))
      else $error("tap read out of range");
`endif

endmodule

@@ src/fir_filter_circular_delay.sv @@
// top level of the circular-delay fir filter
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+--------------------------------------------
//  req     | in  | req_tvalid/req_tready | tdata: coeff_index, value; tuser: command
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: filtered_sample; tuser: clipped
//  csr     | in  | csr_wr_en             | csr_wr_data: tap_count
//
// a sample beat is stored, then each of the n taps in use (tap_count held to 1..MAX_TAPS)
// is read and passed through the shared multiplier, the pipe empties and the sum is loaded;
// no new beat is taken until the sum is loaded. a coefficient beat is written when accepted.
// reset is synchronous; the stores are cleared at once by per-entry written marks.
// a finished result sits in the output register while the next beat is taken; a new
// result waits at the end of its sum until that register is free.
`timescale 1ns / 1ps

module fir_filter_circular_delay #(
   parameter int MAX_TAPS    = fcd_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = fcd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [fcd_pkg::TAP_COUNT_W-1:0] csr_wr_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fcd_pkg::REQ_TDATA_W-1:0] req_tdata,   // [5:0] coeff_index, [21:6] value
   input  logic                            req_tuser,   // [0] command
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fcd_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // [15:0] filtered_sample
   output logic                            rsp_tuser    // [0] clipped
);
   import fcd_pkg::*;

   command_type          req_command;
   logic [INDEX_W-1:0]   req_coeff_index;
   logic [VALUE_W-1:0]   req_value;
   cmd_type              cmd;
   status_type           status;
   logic [OUT_W-1:0]     rsp_filtered_sample;
   logic                 rsp_clipped;

   // unpack the request beat
   assign req_command     = command_type'(req_tuser);
   assign req_coeff_index = req_tdata[INDEX_W-1:0];
   assign req_value       = req_tdata[INDEX_W+VALUE_W-1:INDEX_W];

   // sequencer
   fcd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd)
   );

   // stores and multiply-accumulate
   fcd_datapath #(
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_coeff_index     (req_coeff_index),
      .req_value           (req_value),
      .cmd                 (cmd),
      .status              (status),
      .rsp_tready          (rsp_tready),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_filtered_sample (rsp_filtered_sample),
      .rsp_clipped         (rsp_clipped)
   );

   // pack the result beat
   assign rsp_tdata = rsp_filtered_sample;
   assign rsp_tuser = rsp_clipped;

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for the circular-delay fir filter
`timescale 1ns / 1ps

module tb_top;
   import fcd_pkg::*;

   localparam int NTAPS     = MAX_TAPS_DEF;
   localparam int SEG_BEATS = 106;
   localparam int NSEGS     = 8;
   localparam int SETTLE    = 8;
   localparam int DRAIN_MAX = 50000;
   localparam int PAD_W     = REQ_TDATA_W - VALUE_W - INDEX_W;
   localparam longint SAT_HI = 2 ** (OUT_W - 1) - 1;
   localparam longint SAT_LO = -SAT_HI - 1;

   // one request beat as queued for the driver
   typedef struct packed {
      command_type        cmd;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
      logic               hold_drain;   // wait for all results before sending
   } fir_beat_type;

   // one expected response beat
   typedef struct packed {
      logic [OUT_W-1:0] sample;
      logic             clipped;
   } fir_out_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [TAP_COUNT_W-1:0] csr_wr_data = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   req_tuser   = CMD_SAMPLE;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;

   // predictor state
   logic signed [VALUE_W-1:0] delay_mem [NTAPS];
   logic signed [COEF_W-1:0]  coef_mem  [NTAPS];
   int unsigned               wr_pos;
   logic [TAP_COUNT_W-1:0]    tap_reg;

   fir_beat_type beats_to_send [$];
   fir_out_type  filter_outputs_due [$];
   fir_beat_type cur_beat;
   logic         req_taken = 1'b0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int beats_queued  = 0;
   int beats_taken   = 0;
   int sample_beats  = 0;
   int coef_beats    = 0;
   int outputs_seen  = 0;
   int clip_seen     = 0;
   int settings_used = 0;
   int err_count     = 0;

   always #5 clock = ~clock;

   fir_filter_circular_delay i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   task automatic report_mismatch(input string msg);
      err_count++;
      if (err_count <= 40) begin
         $display("ERROR at %0t ns: %s", $time, msg);
      end
   endtask

   task automatic clear_model();
      for (int i = 0; i < NTAPS; i++) begin
         delay_mem[i] = '0;
         coef_mem[i]  = '0;
      end
      wr_pos  = 0;
      tap_reg = TAP_COUNT_RESET;
   endtask

   // apply one beat to the predictor, returns 1 when it yields an output
   function automatic bit fir_predict(input fir_beat_type b, output fir_out_type y);
      int unsigned n;
      int unsigned rd;
      longint      acc;
      longint      q;
      y = '0;
      if (b.cmd == CMD_COEF) begin
         coef_mem[b.index] = b.value;
         return 1'b0;
      end
      if (tap_reg == 0) n = 1;
      else if (tap_reg > NTAPS) n = NTAPS;
      else n = tap_reg;
      // store at the old position even when it lies past a reduced tap count
      delay_mem[wr_pos] = b.value;
      wr_pos++;
      if (wr_pos >= n) wr_pos = 0;
      // coefficient 0 meets the oldest sample
      acc = 0;
      rd  = wr_pos;
      for (int k = 0; k < n; k++) begin
         acc += longint'(coef_mem[k]) * longint'(delay_mem[rd]);
         rd++;
         if (rd >= n) rd = 0;
      end
      q = acc >>> COEF_FRAC;
      if (q > SAT_HI) begin
         y.sample  = SAT_HI[OUT_W-1:0];
         y.clipped = 1'b1;
      end else if (q < SAT_LO) begin
         y.sample  = SAT_LO[OUT_W-1:0];
         y.clipped = 1'b1;
      end else begin
         y.sample = q[OUT_W-1:0];
      end
      return 1'b1;
   endfunction

   // request driver and response back-pressure
   always @(negedge clock) begin : req_driver
      fir_beat_type nxt;
      bit           present;
      nxt     = '0;
      present = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            if (!beats_to_send[0].hold_drain || filter_outputs_due.size() == 0) begin
               nxt     = beats_to_send.pop_front();
               present = 1'b1;
            end
         end
         if (present) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {{PAD_W{1'b0}}, nxt.value, nxt.index};
            req_tuser  <= nxt.cmd;
            cur_beat   <= nxt;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // accept tracking, prediction and response check
   always @(posedge clock) begin : rsp_monitor
      fir_out_type y;
      fir_out_type want;
      y    = '0;
      want = '0;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            beats_taken++;
            if (cur_beat.cmd == CMD_COEF) coef_beats++;
            else sample_beats++;
            if (fir_predict(cur_beat, y)) filter_outputs_due.push_back(y);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (filter_outputs_due.size() == 0) begin
               report_mismatch($sformatf("response beat with none due, data %h", rsp_tdata));
            end else begin
               want = filter_outputs_due.pop_front();
               outputs_seen++;
               if (want.clipped) clip_seen++;
               if (rsp_tdata !== want.sample)
                  report_mismatch($sformatf("filtered_sample %0d, expected %0d",
                     $signed(rsp_tdata), $signed(want.sample)));
               if (rsp_tuser !== want.clipped)
                  report_mismatch($sformatf("clipped %b, expected %b",
                     rsp_tuser, want.clipped));
            end
         end
      end
   end

   function automatic fir_beat_type sample_beat(input logic [VALUE_W-1:0] v);
      fir_beat_type b;
      b       = '0;
      b.cmd   = CMD_SAMPLE;
      b.index = INDEX_W'($urandom);
      b.value = v;
      return b;
   endfunction

   function automatic fir_beat_type coef_beat(input int unsigned idx,
                                              input logic [VALUE_W-1:0] v);
      fir_beat_type b;
      b       = '0;
      b.cmd   = CMD_COEF;
      b.index = INDEX_W'(idx);
      b.value = v;
      return b;
   endfunction

   function automatic logic [VALUE_W-1:0] rand_value();
      logic [VALUE_W-1:0] s;
      s = VALUE_W'($urandom);
      case ($urandom_range(9))
         0: s = 16'h7fff;
         1: s = 16'h8000;
         2, 3: s = VALUE_W'($urandom_range(511)) - 16'd256;
         default: ;
      endcase
      return s;
   endfunction

   task automatic push_beat(input fir_beat_type b);
      beats_to_send.push_back(b);
      beats_queued++;
   endtask

   // wait until every beat is taken and every result is back
   task automatic wait_for_drain(input int extra);
      int guard;
      guard = 0;
      while ((beats_taken != beats_queued || filter_outputs_due.size() != 0)
             && guard < DRAIN_MAX) begin
         @(negedge clock);
         guard++;
      end
      if (beats_taken != beats_queued)
         report_mismatch($sformatf("%0d beats never accepted", beats_queued - beats_taken));
      if (filter_outputs_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", filter_outputs_due.size()));
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_taps(input int unsigned n);
      wait_for_drain(SETTLE);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= TAP_COUNT_W'(n);
      tap_reg      = TAP_COUNT_W'(n);
      settings_used++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned  taps_list [NSEGS];
      fir_beat_type b;
      clear_model();
      taps_list = '{0, 1, 127, 2, 64, 65, 0, 0};
      taps_list[6] = $urandom_range(63, 3);
      taps_list[7] = $urandom_range(63, 3);
      send_idle_pct = 29;
      recv_idle_pct = 58;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extreme coefficients and samples at the reset tap count
      push_beat(coef_beat(63, 16'h7fff));
      push_beat(coef_beat(62, 16'h7fff));
      push_beat(coef_beat(0, 16'h8000));
      push_beat(coef_beat(31, 16'hffff));
      push_beat(sample_beat(16'h7fff));
      push_beat(sample_beat(16'h7fff));   // positive saturation
      push_beat(sample_beat(16'h8000));
      push_beat(sample_beat(16'h8000));   // negative saturation
      push_beat(coef_beat(32, 16'h5555));
      push_beat(sample_beat(16'h0000));
      push_beat(sample_beat(16'hffff));
      b = sample_beat(16'h0001);
      b.hold_drain = 1'b1;
      push_beat(b);
      push_beat(sample_beat(16'h5555));
      push_beat(sample_beat(16'haaaa));
      push_beat(sample_beat(16'h0064));

      // directed: tap count cut below the write position
      write_taps(3);
      push_beat(coef_beat(1, 16'h4000));
      push_beat(coef_beat(2, 16'h7fff));
      push_beat(sample_beat(16'd1000));
      push_beat(sample_beat(-16'sd1000));
      push_beat(sample_beat(16'h7fff));
      push_beat(sample_beat(16'h8000));
      push_beat(sample_beat(16'hfff1));

      // random segments over several tap settings and idle profiles
      for (int seg = 0; seg < NSEGS; seg++) begin
         write_taps(taps_list[seg]);
         if (seg < 3) begin
            send_idle_pct = 29;
            recv_idle_pct = 58;
         end else if (seg < 6) begin
            send_idle_pct = 58;
            recv_idle_pct = 29;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int i = 0; i < SEG_BEATS; i++) begin
            if ($urandom_range(99) < 20) b = coef_beat($urandom_range(NTAPS - 1), rand_value());
            else b = sample_beat(rand_value());
            b.hold_drain = (i == 50) && (seg == 1 || seg == 4);
            push_beat(b);
         end
      end

      wait_for_drain(NTAPS + 16);
      $display("run covered %0d sample beats and %0d coefficient beats over %0d tap settings",
         sample_beats, coef_beats, settings_used);
      $display("%0d filter outputs checked, %0d of them saturated, %0d errors",
         outputs_seen, clip_seen, err_count);
      if (err_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      #5_000_000;
      $display("run limit reached with %0d results outstanding", filter_outputs_due.size());
      $display("FAIL");
      $finish;
   end

endmodule
